>>> sv/gcht_pkg.sv
// Shared types and constants for the group-count hash table.
// Bucket word layout, memory request, result record, request and status codes.
// No dependencies.
`default_nettype none

package gcht_pkg;

	// Bucket count; a power of two, so the start bucket is the low key bits.
	localparam int TABLE_DEPTH = 1024;
	localparam int KEY_BITS    = 64;
	localparam int COUNT_BITS  = 32;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int TOT_W       = $clog2(TABLE_DEPTH + 1);

	// Request codes
	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_READ   = 2'd1;
	localparam logic [1:0] REQ_CLEAR  = 2'd2;

	// Status codes
	localparam logic [2:0] ST_NEW     = 3'd0;
	localparam logic [2:0] ST_INC     = 3'd1;
	localparam logic [2:0] ST_FULL    = 3'd2;
	localparam logic [2:0] ST_READ    = 3'd3;
	localparam logic [2:0] ST_CLEARED = 3'd4;

	typedef struct packed {
		logic                  used;
		logic [COUNT_BITS-1:0] count;
		logic [KEY_BITS-1:0]   key;
	} entry_t;

	typedef struct packed {
		logic             en;
		logic             we;
		logic [IDX_W-1:0] addr;
		entry_t           wdata;
	} mem_req_t;

	typedef struct packed {
		logic [2:0]            status;
		logic [IDX_W-1:0]      slot;
		logic [KEY_BITS-1:0]   key;
		logic [COUNT_BITS-1:0] count;
		logic                  occupied;
		logic [TOT_W-1:0]      total;
		logic                  over;
	} result_t;

endpackage

`default_nettype wire

>>> sv/gcht_mem.sv
// Bucket store: one synchronous single-port memory of entry words.
// Read data is registered. Depends on gcht_pkg.
`default_nettype none

module gcht_mem (
	input  wire logic              clk,
	input  wire gcht_pkg::mem_req_t req,
	output gcht_pkg::entry_t       rdata
);
	import gcht_pkg::*;

	entry_t mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end else if (req.en) begin
			rdata <= mem[req.addr];
		end
	end

endmodule

`default_nettype wire

>>> sv/gcht_ctrl.sv
// Request sequencer: probe walk, bucket read, clearing sweep, result register.
// Drives the bucket store; depends on gcht_pkg.
`default_nettype none

module gcht_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [1:0]                    req_type,
	input  wire logic [gcht_pkg::KEY_BITS-1:0] key,
	input  wire logic [gcht_pkg::IDX_W-1:0]    read_index,
	input  wire logic [gcht_pkg::TOT_W-1:0]    load_limit,
	input  wire gcht_pkg::entry_t              rdata,
	output gcht_pkg::mem_req_t                 mem_req,
	output logic                               busy,
	output logic                               done,
	output gcht_pkg::result_t                  res
);
	import gcht_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_PROBE = 2'd1;
	localparam logic [1:0] S_READ  = 2'd2;
	localparam logic [1:0] S_SWEEP = 2'd3;

	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [IDX_W-1:0]      IDX_MAX = {IDX_W{1'b1}};

	logic [1:0]          state_q, state_n;
	logic [IDX_W-1:0]    idx_q, idx_n;
	logic [IDX_W-1:0]    probe_q, probe_n;
	logic [KEY_BITS-1:0] key_q, key_n;
	logic [TOT_W-1:0]    used_q, used_n;
	logic                clr_pend_q, clr_pend_n;
	logic                done_n;
	result_t             res_n;
	logic                accept;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);

	always_comb begin
		state_n    = state_q;
		idx_n      = idx_q;
		probe_n    = probe_q;
		key_n      = key_q;
		used_n     = used_q;
		clr_pend_n = clr_pend_q;
		done_n     = 1'b0;
		res_n      = '0;
		mem_req    = '0;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req_type)
						REQ_INSERT: begin
							mem_req.en   = 1'b1;
							mem_req.addr = key[IDX_W-1:0];
							idx_n        = key[IDX_W-1:0];
							key_n        = key;
							probe_n      = '0;
							state_n      = S_PROBE;
						end
						REQ_READ: begin
							mem_req.en   = 1'b1;
							mem_req.addr = read_index;
							idx_n        = read_index;
							state_n      = S_READ;
						end
						REQ_CLEAR: begin
							idx_n      = '0;
							used_n     = '0;
							clr_pend_n = 1'b1;
							state_n    = S_SWEEP;
						end
						default: begin
							// undefined request: drop it
						end
					endcase
				end
			end
			S_PROBE: begin
				res_n.key = key_q;
				if (!rdata.used) begin
					mem_req.we         = 1'b1;
					mem_req.addr       = idx_q;
					mem_req.wdata.used  = 1'b1;
					mem_req.wdata.count = COUNT_BITS'(1);
					mem_req.wdata.key   = key_q;
					used_n         = used_q + TOT_W'(1);
					res_n.status   = ST_NEW;
					res_n.slot     = idx_q;
					res_n.count    = COUNT_BITS'(1);
					res_n.occupied = 1'b1;
					done_n         = 1'b1;
					state_n        = S_IDLE;
				end else if (rdata.key == key_q) begin
					mem_req.we          = 1'b1;
					mem_req.addr        = idx_q;
					mem_req.wdata.used  = 1'b1;
					mem_req.wdata.key   = key_q;
					mem_req.wdata.count = (rdata.count == CNT_MAX) ? rdata.count
						: rdata.count + COUNT_BITS'(1);
					res_n.status   = ST_INC;
					res_n.slot     = idx_q;
					res_n.count    = mem_req.wdata.count;
					res_n.occupied = 1'b1;
					done_n         = 1'b1;
					state_n        = S_IDLE;
				end else if (probe_q == IDX_MAX) begin
					res_n.status = ST_FULL;
					done_n       = 1'b1;
					state_n      = S_IDLE;
				end else begin
					// advance to the next bucket, wrapping at the end
					mem_req.en   = 1'b1;
					mem_req.addr = idx_q + IDX_W'(1);
					idx_n        = idx_q + IDX_W'(1);
					probe_n      = probe_q + IDX_W'(1);
				end
			end
			S_READ: begin
				res_n.status   = ST_READ;
				res_n.slot     = idx_q;
				res_n.occupied = rdata.used;
				res_n.key      = rdata.used ? rdata.key : '0;
				res_n.count    = rdata.used ? rdata.count : '0;
				done_n         = 1'b1;
				state_n        = S_IDLE;
			end
			S_SWEEP: begin
				mem_req.we   = 1'b1;
				mem_req.addr = idx_q;
				idx_n        = idx_q + IDX_W'(1);
				if (idx_q == IDX_MAX) begin
					state_n      = S_IDLE;
					done_n       = clr_pend_q;
					clr_pend_n   = 1'b0;
					res_n.status = ST_CLEARED;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase

		res_n.total = used_n;
		res_n.over  = (used_n > load_limit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_SWEEP;
			idx_q      <= '0;
			used_q     <= '0;
			clr_pend_q <= 1'b0;
			done       <= 1'b0;
		end else begin
			state_q    <= state_n;
			idx_q      <= idx_n;
			used_q     <= used_n;
			clr_pend_q <= clr_pend_n;
			done       <= done_n;
		end
	end

	always_ff @(posedge clk) begin
		probe_q <= probe_n;
		key_q   <= key_n;
		if (done_n) begin
			res <= res_n;
		end
	end

endmodule

`default_nettype wire

>>> sv/group_count_hash_table.sv
// Group-by count hash table: top level with ports, load-limit register, assertions.
// Instantiates gcht_ctrl and gcht_mem; depends on gcht_pkg.
//
// The block counts 64-bit keys in a 1024-bucket open-addressed table with linear
// probing (start bucket = low 10 key bits, wrap at the end). A request is taken
// when start is high and busy is low; each request other than the undefined code
// gives exactly one result beat, shown for one cycle with done high, which the
// receiver must take then - there is no way to hold it off. An insert probes one
// bucket per cycle, since each probe is one read of the single-port bucket memory,
// and is busy through the probe walk; the result is registered after the last
// probe. A read fetches one bucket and reports it. A clear sweeps all 1024 buckets,
// one bucket a cycle, and reports when the sweep ends. The same sweep runs after
// reset, with busy high and no result. A full table reports status 2 after 1024
// probes. The load limit may be written at any time through cfg_valid / cfg_ready
// (always ready) but should change only while the block is idle; over_load
// compares the new occupied total against it when a result is formed.
`default_nettype none

module group_count_hash_table (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  req_type,
	input  wire logic [63:0] key,
	input  wire logic [9:0]  read_index,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [10:0] cfg_data,
	output logic             done,
	output logic [2:0]       status,
	output logic [9:0]       slot_index,
	output logic [63:0]      entry_key,
	output logic [31:0]      entry_count,
	output logic             entry_occupied,
	output logic [10:0]      occupied_total,
	output logic             over_load
);
	import gcht_pkg::*;

	localparam logic [TOT_W-1:0] LOAD_LIMIT_RST = TOT_W'(716);

	logic [TOT_W-1:0] load_limit_q;
	mem_req_t         mem_req;
	entry_t           rdata;
	result_t          res;

	// Configuration channel: always ready, hold the limit until the next beat.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_limit_q <= LOAD_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			load_limit_q <= cfg_data;
		end
	end

	// Sequencer: walks probes, reads buckets, sweeps on clear and after reset.
	gcht_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.req_type   (req_type),
		.key        (key),
		.read_index (read_index),
		.load_limit (load_limit_q),
		.rdata      (rdata),
		.mem_req    (mem_req),
		.busy       (busy),
		.done       (done),
		.res        (res)
	);

	// Bucket memory: used flag, count and key in one word per bucket.
	gcht_mem u_mem (
		.clk   (clk),
		.req   (mem_req),
		.rdata (rdata)
	);

	// Result beat straight from the sequencer's result register.
	assign status         = res.status;
	assign slot_index     = res.slot;
	assign entry_key      = res.key;
	assign entry_count    = res.count;
	assign entry_occupied = res.occupied;
	assign occupied_total = res.total;
	assign over_load      = res.over;

`ifndef SYNTHESIS
	a_total_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (occupied_total <= TOT_W'(TABLE_DEPTH)))
		else $error("occupied total beyond table depth");

	a_new_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_NEW) |-> (entry_occupied && entry_count == 32'd1))
		else $error("new key not reported with count one");

	a_clear_total: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_CLEARED) |-> (occupied_total == '0 && !over_load))
		else $error("clear left occupied buckets");

	a_empty_read: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_READ && !entry_occupied)
			|-> (entry_key == '0 && entry_count == '0))
		else $error("empty bucket read shows stale contents");
`endif

endmodule

`default_nettype wire

>>> test/group_count_hash_table_test.sv
// Self-checking bench for group_count_hash_table: directed probes, then random phases.
// Keeps its own copy of the bucket table to predict every result beat.
// Depends on gcht_pkg and the group_count_hash_table RTL only.
`timescale 1ns / 1ps

module group_count_hash_table_test;
	import gcht_pkg::*;

	localparam int         HALF_PERIOD    = 4;
	localparam int         RESET_CYCLES   = 10;
	// A clear sweep or a full-table probe walk leaves every channel quiet throughout; allow headroom.
	localparam int         QUIET_LIMIT    = 8000;
	// Cycles to let pass once nothing is due, since an ignored request leaves no beat.
	localparam int         SETTLE_CYCLES  = 8;
	localparam int         KEY_POOL_SIZE  = 24;
	localparam int         MAX_PRINTED    = 40;
	localparam logic [1:0] REQ_UNDEFINED  = 2'd3;
	localparam logic [10:0] LOAD_LIMIT_RESET = 11'd716;

	typedef struct {
		logic [1:0]  kind;
		logic [63:0] key;
		logic [9:0]  idx;
	} request_t;

	// DUT ports
	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        start      = 1'b0;
	logic [1:0]  req_type   = REQ_INSERT;
	logic [63:0] key        = '0;
	logic [9:0]  read_index = '0;
	logic        cfg_valid  = 1'b0;
	logic [10:0] cfg_data   = '0;
	logic        busy;
	logic        cfg_ready;
	logic        done;
	logic [2:0]  status;
	logic [9:0]  slot_index;
	logic [63:0] entry_key;
	logic [31:0] entry_count;
	logic        entry_occupied;
	logic [10:0] occupied_total;
	logic        over_load;

	group_count_hash_table dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.req_type       (req_type),
		.key            (key),
		.read_index     (read_index),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.done           (done),
		.status         (status),
		.slot_index     (slot_index),
		.entry_key      (entry_key),
		.entry_count    (entry_count),
		.entry_occupied (entry_occupied),
		.occupied_total (occupied_total),
		.over_load      (over_load)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// Shadow copy of the bucket table and the load-limit register.
	logic [KEY_BITS-1:0]   tbl_key   [TABLE_DEPTH];
	logic [COUNT_BITS-1:0] tbl_count [TABLE_DEPTH];
	bit                    tbl_used  [TABLE_DEPTH];
	logic [TOT_W-1:0]      used_count      = '0;
	logic [10:0]           load_limit_copy = LOAD_LIMIT_RESET;

	request_t    pending_reqs [$];   // requests not yet offered to the block
	result_t     due_results  [$];   // predicted beats, oldest first
	request_t    cur_req;
	bit          req_loaded   = 1'b0;
	int          sender_idle_pct = 0;
	int          mismatches   = 0;
	int          reqs_taken   = 0;
	int          beats_seen   = 0;
	int          status_seen [8];
	logic [63:0] key_pool [KEY_POOL_SIZE];

	task automatic flag_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatches++;
		if (mismatches <= MAX_PRINTED)
			$display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
	endtask

	// Walk the shadow table exactly as the block should, update it, and queue the beat.
	task automatic apply_to_table(input request_t rq);
		result_t          r;
		logic [IDX_W-1:0] idx;
		bit               hit;
		r = '0;
		case (rq.kind)
			REQ_INSERT: begin
				idx = rq.key[IDX_W-1:0];
				hit = 1'b0;
				for (int n = 0; n < TABLE_DEPTH && !hit; n++) begin
					if (!tbl_used[idx]) begin
						// first empty bucket on the probe path takes the key
						tbl_used[idx]  = 1'b1;
						tbl_key[idx]   = rq.key;
						tbl_count[idx] = 1;
						used_count     = used_count + 1'b1;
						r.status = ST_NEW;
						hit = 1'b1;
					end else if (tbl_key[idx] == rq.key) begin
						// hold the count at its maximum once saturated
						if (tbl_count[idx] != '1)
							tbl_count[idx] = tbl_count[idx] + 1'b1;
						r.status = ST_INC;
						hit = 1'b1;
					end else begin
						idx = idx + 1'b1;   // advance, wrapping at the last bucket
					end
				end
				if (hit) begin
					r.slot     = idx;
					r.key      = rq.key;
					r.count    = tbl_count[idx];
					r.occupied = 1'b1;
				end else begin
					// every bucket holds another key: drop it and report full
					r.status = ST_FULL;
					r.key    = rq.key;
				end
			end
			REQ_READ: begin
				idx = rq.idx;
				r.status = ST_READ;
				r.slot   = idx;
				// an empty bucket never shows the key left behind in it
				if (tbl_used[idx]) begin
					r.key      = tbl_key[idx];
					r.count    = tbl_count[idx];
					r.occupied = 1'b1;
				end
			end
			REQ_CLEAR: begin
				for (int n = 0; n < TABLE_DEPTH; n++) begin
					tbl_used[n]  = 1'b0;
					tbl_count[n] = '0;
				end
				used_count = '0;
				r.status = ST_CLEARED;
			end
			default: return;   // undefined code: no state change, no beat
		endcase
		r.total = used_count;
		r.over  = (used_count > load_limit_copy);
		due_results.push_back(r);
	endtask

	// Driver: offer the next queued request, hold it until the block takes it.
	always @(posedge clk) begin : drive_requests
		bit take;
		take = 1'b0;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				// the beat moved at this edge; predict in acceptance order
				apply_to_table(cur_req);
				reqs_taken++;
				req_loaded = 1'b0;
			end
			if (start && busy) begin
				take = 1'b1;   // hold the current beat
			end else if (pending_reqs.size() != 0 &&
					$urandom_range(0, 99) >= sender_idle_pct) begin
				cur_req    = pending_reqs.pop_front();
				req_loaded = 1'b1;
				take       = 1'b1;
				req_type   <= cur_req.kind;
				key        <= cur_req.key;
				read_index <= cur_req.idx;
			end else begin
				// idle cycle: put noise on the payload, start stays low
				req_type   <= 2'($urandom);
				key        <= {$urandom, $urandom};
				read_index <= 10'($urandom);
			end
			start <= take;
		end
	end

	// Monitor: every done beat must match the oldest prediction.
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && done) begin
			beats_seen++;
			if (due_results.size() == 0) begin
				flag_mismatch("result beat with nothing due, status", 64'(status), '0);
			end else begin
				want = due_results.pop_front();
				status_seen[want.status]++;
				if (status !== want.status)
					flag_mismatch("status", 64'(status), 64'(want.status));
				if (slot_index !== want.slot)
					flag_mismatch("slot_index", 64'(slot_index), 64'(want.slot));
				if (entry_key !== want.key)
					flag_mismatch("entry_key", entry_key, want.key);
				if (entry_count !== want.count)
					flag_mismatch("entry_count", 64'(entry_count), 64'(want.count));
				if (entry_occupied !== want.occupied)
					flag_mismatch("entry_occupied", 64'(entry_occupied), 64'(want.occupied));
				if (occupied_total !== want.total)
					flag_mismatch("occupied_total", 64'(occupied_total), 64'(want.total));
				if (over_load !== want.over)
					flag_mismatch("over_load", 64'(over_load), 64'(want.over));
			end
		end
	end

	// Watchdog: end the run if nothing moves on any channel for too long.
	always @(posedge clk) begin : watchdog
		int quiet;
		if ((start && !busy) || done || (cfg_valid && cfg_ready) || !arst_n) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("timeout after %0d quiet cycles", quiet);
				$display("tb: failure");
				$finish;
			end
		end
	end

	function automatic request_t make_req(input logic [1:0] kind, input logic [63:0] k,
			input logic [9:0] i);
		request_t rq;
		rq.kind = kind;
		rq.key  = k;
		rq.idx  = i;
		return rq;
	endfunction

	// Wait until the driver has nothing left and every due beat has arrived.
	task automatic wait_drained();
		do
			@(posedge clk);
		while (pending_reqs.size() != 0 || req_loaded || due_results.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_load_limit(input logic [10:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		load_limit_copy = value;
		cfg_valid <= 1'b0;
	endtask

	// Mostly inserts from a clustered key pool so probe chains form and wrap;
	// reads lean toward the crowded buckets; clears stay rare since each is a sweep.
	task automatic queue_random_reqs(input int count);
		int          pick;
		logic [63:0] k;
		logic [9:0]  i;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			k = ($urandom_range(0, 9) < 6) ? key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)]
				: {$urandom, $urandom};
			i = ($urandom_range(0, 1) == 0) ? 10'($urandom)
				: (($urandom_range(0, 3) == 0) ? 10'(1016 + $urandom_range(0, 7))
				: 10'($urandom_range(0, 40)));
			if (pick < 72)
				pending_reqs.push_back(make_req(REQ_INSERT, k, i));
			else if (pick < 93)
				pending_reqs.push_back(make_req(REQ_READ, k, i));
			else if (pick < 95)
				pending_reqs.push_back(make_req(REQ_CLEAR, k, i));
			else
				pending_reqs.push_back(make_req(REQ_UNDEFINED, k, i));
		end
	endtask

	// Clear, fill every bucket, push new keys into the full table, revisit stored ones, read, clear again.
	task automatic queue_fill_sequence();
		logic [63:0] stored [$];
		logic [63:0] k;
		pending_reqs.push_back(make_req(REQ_CLEAR, '0, '0));
		for (int n = 0; n < TABLE_DEPTH; n++) begin
			k = {$urandom, $urandom};
			stored.push_back(k);
			pending_reqs.push_back(make_req(REQ_INSERT, k, 10'($urandom)));
		end
		for (int n = 0; n < 5; n++)
			pending_reqs.push_back(make_req(REQ_INSERT, {$urandom, $urandom}, '0));
		for (int n = 0; n < 6; n++)
			pending_reqs.push_back(make_req(REQ_INSERT,
				stored[$urandom_range(0, TABLE_DEPTH - 1)], '0));
		for (int n = 0; n < 16; n++)
			pending_reqs.push_back(make_req(REQ_READ, '0, 10'($urandom)));
		pending_reqs.push_back(make_req(REQ_CLEAR, '0, '0));
	endtask

	initial begin : run_phases
		logic [63:0] k;
		for (int n = 0; n < KEY_POOL_SIZE; n++) begin
			k = {$urandom, $urandom};
			k[9:0] = ($urandom_range(0, 3) == 0) ? 10'(1016 + $urandom_range(0, 7))
				: 10'($urandom_range(0, 31));
			key_pool[n] = k;
		end
		for (int n = 0; n < TABLE_DEPTH; n++) begin
			tbl_used[n]  = 1'b0;
			tbl_count[n] = '0;
			tbl_key[n]   = '0;
		end

		// Reset once; the block then sweeps its memory with busy high.
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty read, new and repeat keys, collisions, wrap past the
		// last bucket, the undefined code, clear, and reads after the clear.
		sender_idle_pct = 0;
		pending_reqs.push_back(make_req(REQ_READ, '0, 10'd0));
		pending_reqs.push_back(make_req(REQ_INSERT, 64'h0, '0));
		pending_reqs.push_back(make_req(REQ_INSERT, 64'h0, '0));
		pending_reqs.push_back(make_req(REQ_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, '0));
		pending_reqs.push_back(make_req(REQ_INSERT, 64'h400, '0));
		pending_reqs.push_back(make_req(REQ_INSERT, 64'h7FF, '0));
		pending_reqs.push_back(make_req(REQ_INSERT, 64'h7FF, '0));
		pending_reqs.push_back(make_req(REQ_READ, '0, 10'h3FF));
		pending_reqs.push_back(make_req(REQ_READ, '0, 10'd2));
		pending_reqs.push_back(make_req(REQ_READ, '0, 10'd3));
		pending_reqs.push_back(make_req(REQ_UNDEFINED, 64'hFFFF_FFFF_FFFF_FFFF, 10'h3FF));
		pending_reqs.push_back(make_req(REQ_INSERT, 64'h8000_0000_0000_0000, '0));
		pending_reqs.push_back(make_req(REQ_READ, '0, 10'd1));
		pending_reqs.push_back(make_req(REQ_CLEAR, '0, '0));
		pending_reqs.push_back(make_req(REQ_READ, '0, 10'd0));
		pending_reqs.push_back(make_req(REQ_INSERT, 64'h400, '0));
		pending_reqs.push_back(make_req(REQ_READ, '0, 10'd0));
		wait_drained();

		// Lowest limit: over-load as soon as one bucket is taken.
		write_load_limit(11'd0);
		sender_idle_pct = 49;
		queue_random_reqs(30);
		wait_drained();

		// Highest limit: over-load can never be raised.
		write_load_limit(11'd1024);
		sender_idle_pct = 0;
		queue_random_reqs(30);
		wait_drained();

		// Small random limit so over-load toggles as the table fills and clears.
		write_load_limit(11'($urandom_range(1, 40)));
		sender_idle_pct = 34;
		queue_random_reqs(30);
		wait_drained();

		// Full table: over-load flips only at the last bucket.
		write_load_limit(11'd1023);
		sender_idle_pct = 34;
		queue_fill_sequence();
		wait_drained();

		write_load_limit(11'($urandom_range(2, 12)));
		sender_idle_pct = 49;
		queue_random_reqs(30);
		wait_drained();

		$display("summary: %0d requests taken, %0d result beats checked", reqs_taken,
			beats_seen);
		$display("summary: new %0d, incremented %0d, full %0d, read %0d, cleared %0d",
			status_seen[ST_NEW], status_seen[ST_INC], status_seen[ST_FULL],
			status_seen[ST_READ], status_seen[ST_CLEARED]);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
